/* hdl/rcr_pkg.sv */
// Package for the radio configuration register responder.
// Holds protocol codes, state types and the register file control struct.
// No dependencies.
`default_nettype none

package rcr_pkg;

  localparam int REG_COUNT_DEF = 9;
  localparam int KEY_FIRST_DEF = 7;
  localparam int RF_ADDR_W     = 4;

  localparam logic [7:0] CMD_WRITE      = 8'hC0;
  localparam logic [7:0] CMD_READ       = 8'hC1;
  localparam logic [7:0] CMD_WRITE_TEMP = 8'hC2;
  localparam logic [7:0] ERR_BYTE       = 8'hFF;
  localparam logic [7:0] MAX_LEN        = 8'd9;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_ADDR,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    PC_READ,
    PC_WRITE,
    PC_WRITE_TEMP,
    PC_REJECT
  } pend_cmd_t;

  typedef enum logic [1:0] {
    ST_RX,
    ST_FETCH,
    ST_LOAD,
    ST_WAIT
  } seq_state_t;

  typedef struct packed {
    logic                 we;
    logic [RF_ADDR_W-1:0] waddr;
    logic [7:0]           wdata;
    logic                 re;
    logic [RF_ADDR_W-1:0] raddr;
  } rf_ctl_t;

endpackage

`default_nettype wire

/* hdl/rcr_if.sv */
// Valid/ready channel interfaces for received bytes and reply bytes.
// No dependencies.
`default_nettype none

interface rcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       reply_last;

  modport source (output valid, output tx_byte, output reply_last, input ready);
  modport sink (input valid, input tx_byte, input reply_last, output ready);
endinterface

`default_nettype wire

/* hdl/rcr_regfile.sv */
// Register file with one write port and one registered read port.
// Key registers read as zero. Depends on rcr_pkg.
`default_nettype none

module rcr_regfile #(
  parameter int REG_COUNT = rcr_pkg::REG_COUNT_DEF,
  parameter int KEY_FIRST = rcr_pkg::KEY_FIRST_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  rcr_pkg::rf_ctl_t  ctl,
  output logic [7:0]        rd_data
);

  localparam logic [4:0] KEY_A = 5'(KEY_FIRST);
  localparam logic [4:0] KEY_B = 5'(KEY_FIRST + 1);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [7:0]           rd_data_r;
  logic                 is_key;

  assign is_key = (5'(ctl.raddr) == KEY_A) || (5'(ctl.raddr) == KEY_B);

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  // An entry never written reads as its reset value of zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.we) begin
      vld_r[ctl.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      if (is_key || !vld_r[ctl.raddr]) begin
        rd_data_r <= 8'h00;
      end else begin
        rd_data_r <= mem[ctl.raddr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/rcr_seq.sv */
// Command parser and reply sequencer around one shared index adder.
// Depends on rcr_pkg and rcr_if; drives the rcr_regfile control struct.
`default_nettype none

module rcr_seq #(
  parameter int REG_COUNT = rcr_pkg::REG_COUNT_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  rcr_in_if.sink             in_ch,
  rcr_out_if.source          out_ch,
  output rcr_pkg::rf_ctl_t   rf_ctl,
  input  wire [7:0]          rf_rd_data
);

  localparam logic [7:0] REG_COUNT_B = 8'(REG_COUNT);
  localparam logic [8:0] REG_COUNT_S = 9'(REG_COUNT);

  rcr_pkg::seq_state_t st_r, st_nxt;
  rcr_pkg::phase_t     ph_r, ph_nxt;
  rcr_pkg::pend_cmd_t  pc_r, pc_nxt;
  logic [3:0] start_r, start_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] taken_r, taken_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] val_r, val_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] tx_byte_r, tx_byte_nxt;
  logic       last_r, last_nxt;

  logic       in_acc;
  logic [7:0] b;
  logic [7:0] opnd;
  logic [8:0] sum;
  logic [3:0] taken_inc;

  assign in_ch.ready       = (st_r == rcr_pkg::ST_RX);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign b                 = in_ch.rx_byte;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_byte    = tx_byte_r;
  assign out_ch.reply_last = last_r;
  assign taken_inc         = taken_r + 4'd1;

  // The one adder: bound check, write address and read address all come from it.
  always_comb begin
    if (st_r == rcr_pkg::ST_RX) begin
      opnd = (ph_r == rcr_pkg::PH_LEN) ? b : {4'b0, taken_r};
    end else begin
      opnd = {4'b0, val_r};
    end
    sum = {5'b0, start_r} + {1'b0, opnd};
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rcr_pkg::ST_RX: begin
        if (in_acc) begin
          case (ph_r)
            rcr_pkg::PH_LEN: begin
              if (pc_r == rcr_pkg::PC_REJECT || b > rcr_pkg::MAX_LEN ||
                  sum > REG_COUNT_S || pc_r == rcr_pkg::PC_READ || b == 8'd0) begin
                st_nxt = rcr_pkg::ST_FETCH;
              end
            end
            rcr_pkg::PH_DATA: begin
              if (taken_inc >= cnt_r) begin
                st_nxt = rcr_pkg::ST_FETCH;
              end
            end
            default: st_nxt = rcr_pkg::ST_RX;
          endcase
        end
      end
      rcr_pkg::ST_FETCH: st_nxt = rcr_pkg::ST_LOAD;
      rcr_pkg::ST_LOAD:  st_nxt = rcr_pkg::ST_WAIT;
      rcr_pkg::ST_WAIT: begin
        if (out_ch.ready) begin
          st_nxt = last_r ? rcr_pkg::ST_RX : rcr_pkg::ST_FETCH;
        end
      end
      default: st_nxt = rcr_pkg::ST_RX;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ph_nxt        = ph_r;
    pc_nxt        = pc_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    taken_nxt     = taken_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    tx_byte_nxt   = tx_byte_r;
    last_nxt      = last_r;
    rf_ctl        = '0;
    rf_ctl.waddr  = sum[rcr_pkg::RF_ADDR_W-1:0];
    rf_ctl.wdata  = b;
    rf_ctl.raddr  = sum[rcr_pkg::RF_ADDR_W-1:0];

    case (st_r)
      rcr_pkg::ST_RX: begin
        if (in_acc) begin
          pos_nxt = 4'd0;
          val_nxt = 4'd0;
          case (ph_r)
            rcr_pkg::PH_CMD: begin
              case (b)
                rcr_pkg::CMD_READ:       pc_nxt = rcr_pkg::PC_READ;
                rcr_pkg::CMD_WRITE:      pc_nxt = rcr_pkg::PC_WRITE;
                rcr_pkg::CMD_WRITE_TEMP: pc_nxt = rcr_pkg::PC_WRITE_TEMP;
                default:                 pc_nxt = rcr_pkg::PC_REJECT;
              endcase
              start_nxt = 4'd0;
              cnt_nxt   = 4'd0;
              taken_nxt = 4'd0;
              ph_nxt    = rcr_pkg::PH_ADDR;
            end
            rcr_pkg::PH_ADDR: begin
              if (b >= REG_COUNT_B) begin
                pc_nxt = rcr_pkg::PC_REJECT;
              end else begin
                start_nxt = b[3:0];
              end
              ph_nxt = rcr_pkg::PH_LEN;
            end
            rcr_pkg::PH_LEN: begin
              ph_nxt = rcr_pkg::PH_CMD;
              if (pc_r == rcr_pkg::PC_REJECT || b > rcr_pkg::MAX_LEN ||
                  sum > REG_COUNT_S) begin
                err_nxt = 1'b1;
              end else begin
                err_nxt   = 1'b0;
                cnt_nxt   = b[3:0];
                taken_nxt = 4'd0;
                if (pc_r != rcr_pkg::PC_READ && b != 8'd0) begin
                  ph_nxt = rcr_pkg::PH_DATA;
                end
              end
            end
            default: begin
              rf_ctl.we = 1'b1;
              taken_nxt = taken_inc;
              err_nxt   = 1'b0;
              if (taken_inc >= cnt_r) begin
                ph_nxt = rcr_pkg::PH_CMD;
              end
            end
          endcase
        end
      end
      rcr_pkg::ST_FETCH: begin
        rf_ctl.re = 1'b1;
      end
      rcr_pkg::ST_LOAD: begin
        out_valid_nxt = 1'b1;
        if (err_r) begin
          tx_byte_nxt = rcr_pkg::ERR_BYTE;
          last_nxt    = (pos_r == 4'd2);
        end else begin
          case (pos_r)
            4'd0: begin
              tx_byte_nxt = rcr_pkg::CMD_READ;
              last_nxt    = 1'b0;
            end
            4'd1: begin
              tx_byte_nxt = {4'b0, start_r};
              last_nxt    = 1'b0;
            end
            4'd2: begin
              tx_byte_nxt = {4'b0, cnt_r};
              last_nxt    = (cnt_r == 4'd0);
            end
            default: begin
              tx_byte_nxt = rf_rd_data;
              last_nxt    = ((val_r + 4'd1) == cnt_r);
            end
          endcase
        end
      end
      rcr_pkg::ST_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          pos_nxt       = pos_r + 4'd1;
          if (!err_r && pos_r >= 4'd3) begin
            val_nxt = val_r + 4'd1;
          end
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rcr_pkg::ST_RX;
      ph_r        <= rcr_pkg::PH_CMD;
      pc_r        <= rcr_pkg::PC_READ;
      start_r     <= 4'd0;
      cnt_r       <= 4'd0;
      taken_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      pc_r        <= pc_nxt;
      start_r     <= start_nxt;
      cnt_r       <= cnt_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    err_r     <= err_nxt;
    tx_byte_r <= tx_byte_nxt;
    last_r    <= last_nxt;
  end

endmodule

`default_nettype wire

/* hdl/radio_config_register_responder.sv */
// Header, address and data bytes are taken without a reply byte of their own.
// After the byte that completes a request, the register file read and load states come
// before the first reply byte is valid. Each reply byte goes through register file read,
// load and output handshake, and the sink may stall the handshake; a reply is 3 to 12 bytes.
// No byte is taken while a reply is in progress. Synchronous reset clears the parser
// and marks every register as zero.
`default_nettype none

module radio_config_register_responder #(
  parameter int REG_COUNT = rcr_pkg::REG_COUNT_DEF,
  parameter int KEY_FIRST = rcr_pkg::KEY_FIRST_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  rcr_in_if.sink     in_ch,
  rcr_out_if.source  out_ch
);

  rcr_pkg::rf_ctl_t rf_ctl;
  logic [7:0]       rf_rd_data;

  rcr_seq #(
    .REG_COUNT (REG_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .rf_ctl     (rf_ctl),
    .rf_rd_data (rf_rd_data)
  );

  rcr_regfile #(
    .REG_COUNT (REG_COUNT),
    .KEY_FIRST (KEY_FIRST)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rf_ctl),
    .rd_data (rf_rd_data)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for radio_config_register_responder: drives request bytes,
// predicts every reply byte and compares it with what the block sends back.
// Depends on rcr_pkg and the channel interfaces in rcr_if.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_COUNT = rcr_pkg::REG_COUNT_DEF;
  localparam int KEY_FIRST = rcr_pkg::KEY_FIRST_DEF;
  localparam logic [7:0] CMD_BOGUS = 8'h12;
  localparam int DIR_ROWS = 27;
  localparam int RAND_BYTES = 120;
  localparam int CALM_TAIL = 30;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } reply_t;

  // A row whose typed flag is set carries its three-byte reply in e0..e2.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Full read right after reset: every register is zero.
    '{rcr_pkg::CMD_READ, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h09, 1'b0, 8'h00, 8'h00, 8'h00},
    '{rcr_pkg::CMD_WRITE, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hA5, 1'b0, 8'h00, 8'h00, 8'h00},
    // The key registers take the write but read back as zero.
    '{rcr_pkg::CMD_WRITE_TEMP, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h07, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h02, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{CMD_BOGUS, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b1, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE},
    '{rcr_pkg::CMD_WRITE, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b1, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE},
    '{rcr_pkg::CMD_READ, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h05, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h05, 1'b1, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE, rcr_pkg::ERR_BYTE},
    '{rcr_pkg::CMD_WRITE, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b1, rcr_pkg::CMD_READ, 8'h03, 8'h00},
    '{rcr_pkg::CMD_READ, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h09, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  logic clk = 1'b0;
  logic rst_n;

  rcr_in_if  in_ch ();
  rcr_out_if out_ch ();

  radio_config_register_responder #(
    .REG_COUNT(REG_COUNT),
    .KEY_FIRST(KEY_FIRST)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the parser and register file.
  rcr_pkg::phase_t    rx_phase;
  rcr_pkg::pend_cmd_t rx_cmd;
  logic [3:0] req_addr;
  logic [3:0] req_len;
  logic [3:0] data_seen;
  logic [7:0] shadow_regs [16];

  reply_t predicted_reply [$];
  reply_t awaited_reply [$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  calm = 1'b0;

  function automatic void note_mismatch(string what, reply_t want, reply_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("mismatch (%s): expected tx_byte=%h reply_last=%b, got tx_byte=%h reply_last=%b",
               what, want.tx, want.last, got.tx, got.last);
    end
  endfunction

  function automatic void queue_readback();
    logic [3:0] idx;
    predicted_reply.push_back(reply_t'{rcr_pkg::CMD_READ, 1'b0});
    predicted_reply.push_back(reply_t'{{4'h0, req_addr}, 1'b0});
    predicted_reply.push_back(reply_t'{{4'h0, req_len}, req_len == 4'd0});
    for (int i = 0; i < int'(req_len); i++) begin
      idx = req_addr + 4'(i);
      if (int'(idx) == KEY_FIRST || int'(idx) == KEY_FIRST + 1) begin
        predicted_reply.push_back(reply_t'{8'h00, i + 1 == int'(req_len)});
      end else begin
        predicted_reply.push_back(reply_t'{shadow_regs[idx], i + 1 == int'(req_len)});
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    case (rx_phase)
      rcr_pkg::PH_CMD: begin
        case (b)
          rcr_pkg::CMD_READ:       rx_cmd = rcr_pkg::PC_READ;
          rcr_pkg::CMD_WRITE:      rx_cmd = rcr_pkg::PC_WRITE;
          rcr_pkg::CMD_WRITE_TEMP: rx_cmd = rcr_pkg::PC_WRITE_TEMP;
          default:                 rx_cmd = rcr_pkg::PC_REJECT;
        endcase
        req_addr = '0;
        req_len = '0;
        data_seen = '0;
        rx_phase = rcr_pkg::PH_ADDR;
      end
      rcr_pkg::PH_ADDR: begin
        if (int'(b) >= REG_COUNT) rx_cmd = rcr_pkg::PC_REJECT;
        else req_addr = b[3:0];
        rx_phase = rcr_pkg::PH_LEN;
      end
      rcr_pkg::PH_LEN: begin
        rx_phase = rcr_pkg::PH_CMD;
        if (rx_cmd == rcr_pkg::PC_REJECT || b > rcr_pkg::MAX_LEN ||
            int'(req_addr) + int'(b) > REG_COUNT) begin
          predicted_reply.push_back(reply_t'{rcr_pkg::ERR_BYTE, 1'b0});
          predicted_reply.push_back(reply_t'{rcr_pkg::ERR_BYTE, 1'b0});
          predicted_reply.push_back(reply_t'{rcr_pkg::ERR_BYTE, 1'b1});
        end else begin
          req_len = b[3:0];
          data_seen = '0;
          if (rx_cmd == rcr_pkg::PC_READ || req_len == 4'd0) queue_readback();
          else rx_phase = rcr_pkg::PH_DATA;
        end
      end
      default: begin
        shadow_regs[req_addr + data_seen] = b;
        data_seen = data_seen + 4'd1;
        if (data_seen >= req_len) begin
          rx_phase = rcr_pkg::PH_CMD;
          queue_readback();
        end
      end
    endcase
  endfunction

  // Drives one byte, waits for its transaction and updates the prediction.
  // With keep low the predicted reply is dropped because the caller typed it in.
  task automatic send_byte(input logic [7:0] b, input bit keep);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b);
    if (keep) begin
      while (predicted_reply.size() != 0) awaited_reply.push_back(predicted_reply.pop_front());
    end else begin
      predicted_reply.delete();
    end
    bytes_sent++;
    if (bytes_sent >= DIR_ROWS + RAND_BYTES - CALM_TAIL) quiet = 1'b1;
  endtask

  task automatic finish_data();
    while (rx_phase == rcr_pkg::PH_DATA) send_byte(8'($urandom), 1'b1);
  endtask

  // Sink side: random stall bursts until the quiet tail.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.tx_byte, out_ch.reply_last};
      if (awaited_reply.size() == 0) begin
        note_mismatch("reply byte with nothing expected", '0, got);
      end else begin
        want = awaited_reply.pop_front();
        if (got.tx !== want.tx) note_mismatch("tx_byte", want, got);
        else if (got.last !== want.last) note_mismatch("reply_last", want, got);
      end
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         kind;
    int         rand_start;
    logic [7:0] addr;
    rx_phase = rcr_pkg::PH_CMD;
    rx_cmd = rcr_pkg::PC_READ;
    req_addr = '0;
    req_len = '0;
    data_seen = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TABLE[i].rx, !DIR_TABLE[i].typed);
      if (DIR_TABLE[i].typed) begin
        awaited_reply.push_back(reply_t'{DIR_TABLE[i].e0, 1'b0});
        awaited_reply.push_back(reply_t'{DIR_TABLE[i].e1, 1'b0});
        awaited_reply.push_back(reply_t'{DIR_TABLE[i].e2, 1'b1});
      end
    end

    // Mostly well-formed requests with random content, mixed with broken headers and noise.
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        case ($urandom_range(0, 2))
          0:       send_byte(rcr_pkg::CMD_READ, 1'b1);
          1:       send_byte(rcr_pkg::CMD_WRITE, 1'b1);
          default: send_byte(rcr_pkg::CMD_WRITE_TEMP, 1'b1);
        endcase
        addr = 8'($urandom_range(0, REG_COUNT - 1));
        send_byte(addr, 1'b1);
        send_byte(8'($urandom_range(0, REG_COUNT - int'(addr))), 1'b1);
        finish_data();
      end else if (kind <= 8) begin
        repeat (3) send_byte(8'($urandom), 1'b1);
        finish_data();
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b1);
      end
    end
    while (rx_phase != rcr_pkg::PH_CMD) send_byte(8'($urandom), 1'b1);
    in_ch.valid <= 1'b0;

    while (awaited_reply.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_reply.size() != 0) begin
      mismatches += awaited_reply.size();
      $display("%0d expected reply bytes never arrived", awaited_reply.size());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rcr_pkg.sv
hdl/rcr_if.sv
hdl/rcr_regfile.sv
hdl/rcr_seq.sv
hdl/radio_config_register_responder.sv
bench/tb.sv
